// ----- src/ucdf_pkg.sv -----
// types and constants shared by the usb-can adapter frame deframer
package ucdf_pkg;

    typedef enum logic [1:0] {
        KIND_STRAY   = 2'd0,
        KIND_UNKNOWN = 2'd1,
        KIND_CMD     = 2'd2,
        KIND_DATA    = 2'd3
    } frame_kind_t;

    localparam logic [7:0] HDR_BYTE     = 8'hAA;
    localparam logic [7:0] CMD_BYTE     = 8'h55;
    localparam logic [3:0] DATA_NIBBLE  = 4'hC;
    localparam logic [4:0] CMD_LEN      = 5'd20;
    localparam logic [4:0] CMD_SUM_LAST = 5'd18;
    localparam logic [4:0] DATA_FIRST   = 5'd4;
    localparam int         LANES        = 8;

    typedef struct packed {
        frame_kind_t  frame_kind;
        logic [4:0]   frame_length;
        logic         checksum_ok;
        logic [7:0]   command_code;
        logic [15:0]  can_id;
        logic [3:0]   data_length_code;
        logic         is_extended;
        logic         is_remote;
        logic [63:0]  payload;
    } result_t;

endpackage

// ----- src/usb_can_adapter_frame_deframer_top.sv -----
// top level of the usb-can adapter frame deframer
// Takes one byte per cycle on the rx side while in_stall is low and reports one result
// per completed frame (stray byte, unknown header, 20-byte command frame or dlc+5-byte
// data frame). Each byte updates the registered frame state; a finished frame is written
// at the same edge to the result register, or to a second one behind it if out_stall
// holds the first, so an unstalled result appears the cycle after its last byte. The
// second register keeps the rx side running while out_stall is high; in_stall rises
// only once both hold a result, and one byte per cycle is sustained while out_stall is low.
module usb_can_adapter_frame_deframer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  frame_kind,
    output logic [4:0]  frame_length,
    output logic        checksum_ok,
    output logic [7:0]  command_code,
    output logic [15:0] can_id,
    output logic [3:0]  data_length_code,
    output logic        is_extended,
    output logic        is_remote,
    output logic [63:0] payload
);

    logic [4:0]           pos_reg, pos_next;
    ucdf_pkg::frame_kind_t kind_reg, kind_next;
    logic [7:0]           info_reg, info_next;
    logic [15:0]          id_reg, id_next;
    logic [63:0]          data_reg, data_next;
    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           cmd_reg, cmd_next;

    ucdf_pkg::result_t    res;
    logic                 res_emit;
    logic                 accept;
    logic [4:0]           data_end;

    ucdf_pkg::result_t    out_reg, skid_reg;
    logic                 out_valid_reg, skid_valid_reg;
    logic                 out_fire;

    assign accept   = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;
    assign data_end = {1'b0, info_reg[3:0]} + ucdf_pkg::DATA_FIRST;

    // frame state and result
    always_comb
    begin
        pos_next  = pos_reg;
        kind_next = kind_reg;
        info_next = info_reg;
        id_next   = id_reg;
        data_next = data_reg;
        sum_next  = sum_reg;
        cmd_next  = cmd_reg;
        res_emit  = 1'b0;

        res                  = '0;
        res.frame_kind       = ucdf_pkg::KIND_STRAY;
        res.checksum_ok      = 1'b1;

        if (pos_reg == 5'd0)
        begin
            if (rx_byte != ucdf_pkg::HDR_BYTE)
            begin
                res_emit         = 1'b1;
                res.frame_length = 5'd1;
            end
            else
            begin
                pos_next  = 5'd1;
                kind_next = ucdf_pkg::KIND_STRAY;
                info_next = '0;
                id_next   = '0;
                data_next = '0;
                sum_next  = '0;
                cmd_next  = '0;
            end
        end
        else if (pos_reg == 5'd1)
        begin
            info_next = rx_byte;
            if (rx_byte == ucdf_pkg::CMD_BYTE)
            begin
                kind_next = ucdf_pkg::KIND_CMD;
                pos_next  = 5'd2;
            end
            else if (rx_byte[7:4] == ucdf_pkg::DATA_NIBBLE)
            begin
                kind_next = ucdf_pkg::KIND_DATA;
                pos_next  = 5'd2;
            end
            else
            begin
                kind_next        = ucdf_pkg::KIND_STRAY;
                pos_next         = 5'd0;
                res_emit         = 1'b1;
                res.frame_kind   = ucdf_pkg::KIND_UNKNOWN;
                res.frame_length = 5'd2;
            end
        end
        else if (kind_reg == ucdf_pkg::KIND_CMD)
        begin
            if (pos_reg == 5'd2)
            begin
                cmd_next = rx_byte;
            end
            if (pos_reg <= ucdf_pkg::CMD_SUM_LAST)
            begin
                sum_next = sum_reg + rx_byte;
            end
            if (pos_reg >= ucdf_pkg::CMD_LEN - 5'd1)
            begin
                pos_next         = 5'd0;
                kind_next        = ucdf_pkg::KIND_STRAY;
                res_emit         = 1'b1;
                res.frame_kind   = ucdf_pkg::KIND_CMD;
                res.frame_length = ucdf_pkg::CMD_LEN;
                res.checksum_ok  = (sum_reg == rx_byte);
                res.command_code = cmd_reg;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
        else if (kind_reg == ucdf_pkg::KIND_DATA)
        begin
            if (pos_reg == 5'd2)
            begin
                id_next = {8'd0, rx_byte};
            end
            else if (pos_reg == 5'd3)
            begin
                id_next = {rx_byte, id_reg[7:0]};
            end
            for (int lane = 0; lane < ucdf_pkg::LANES; lane++)
            begin
                if ((pos_reg == ucdf_pkg::DATA_FIRST + 5'(lane)) && (pos_reg < data_end))
                begin
                    data_next[lane*8 +: 8] = rx_byte;
                end
            end
            if (pos_reg >= data_end)
            begin
                pos_next             = 5'd0;
                kind_next            = ucdf_pkg::KIND_STRAY;
                res_emit             = 1'b1;
                res.frame_kind       = ucdf_pkg::KIND_DATA;
                res.frame_length     = data_end + 5'd1;
                res.can_id           = id_reg;
                res.data_length_code = info_reg[3:0];
                res.is_extended      = info_reg[5];
                res.is_remote        = info_reg[4];
                res.payload          = data_reg;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
        else
        begin
            // inconsistent open frame, close it quietly
            pos_next  = 5'd0;
            kind_next = ucdf_pkg::KIND_STRAY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            kind_reg <= ucdf_pkg::KIND_STRAY;
            info_reg <= '0;
            id_reg   <= '0;
            data_reg <= '0;
            sum_reg  <= '0;
            cmd_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            kind_reg <= kind_next;
            info_reg <= info_next;
            id_reg   <= id_next;
            data_reg <= data_next;
            sum_reg  <= sum_next;
            cmd_reg  <= cmd_next;
        end
    end

    // result register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && res_emit)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && res_emit)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign frame_kind       = out_reg.frame_kind;
    assign frame_length     = out_reg.frame_length;
    assign checksum_ok      = out_reg.checksum_ok;
    assign command_code     = out_reg.command_code;
    assign can_id           = out_reg.can_id;
    assign data_length_code = out_reg.data_length_code;
    assign is_extended      = out_reg.is_extended;
    assign is_remote        = out_reg.is_remote;
    assign payload          = out_reg.payload;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= ucdf_pkg::CMD_LEN - 5'd1)
        else $error("byte position beyond longest frame");

    a_stray_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.frame_kind == ucdf_pkg::KIND_STRAY)
        |-> (out_reg.frame_length == 5'd1))
        else $error("stray byte result with wrong length");

    a_cmd_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.frame_kind == ucdf_pkg::KIND_CMD)
        |-> (out_reg.frame_length == ucdf_pkg::CMD_LEN))
        else $error("command result with wrong length");

    a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("stalled result dropped");
`endif

endmodule
